// ----- hdl/nrcf_pkg.sv -----
// Shared types and constants for the neighbour range clamp filter.
// No dependencies; imported by every other module of the block except nrcf_ram.
`default_nettype none

package nrcf_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int CNT_W       = COL_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_W     = 13;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DIFF     = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [12:0] line_width;
    logic [12:0] frame_height;
    logic [7:0]  range_margin;
  } cfg_t;

  // Classified transaction, waiting for its line store read data
  typedef struct packed {
    logic [7:0] px;
    logic       bank;
    logic       is_drain;
    logic       first_col;
    logic       last_col;
    logic       has_up;
    logic       end_of_frame;
  } desc_t;

  // Queue entry: everything the back end needs for one result
  typedef struct packed {
    logic [7:0] px;
    logic [7:0] centre;
    logic [7:0] side;
    logic [7:0] above;
    logic       is_drain;
    logic       first_col;
    logic       last_col;
    logic       has_up;
    logic       end_of_frame;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/nrcf_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module nrcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- hdl/nrcf_front.sv -----
// Front end: accepts input transactions, tracks column/row/bank, writes and reads
// the two line store banks and hands classified items to the queue. Uses nrcf_pkg, nrcf_ram.
`default_nettype none

module nrcf_front
  import nrcf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [7:0]        in_pixel,
  input  wire logic [QCNT_W-1:0] q_count,
  output logic                   push,
  output entry_t                 push_entry
);

  logic [COL_W-1:0] column_count;
  logic [12:0]      row_count;
  logic             bank_select;
  logic             stage_valid;
  desc_t            stage;

  logic [31:0]       lw_ext;
  logic [CNT_W-1:0]  w;
  logic [12:0]       h;
  logic [COL_W-1:0]  col;
  logic [CNT_W-1:0]  col_plus;
  logic              is_last;
  logic              pix_live;
  logic              drain_live;
  logic              emit;
  logic              accept;
  logic [QCNT_W-1:0] used;
  logic [COL_W-1:0]  raddr_b;
  logic [1:0]        we;
  logic [7:0]        rd_a [2];
  logic [7:0]        rd_b [2];

  always_comb begin
    lw_ext = 32'(cfg.line_width);
    if (lw_ext == 32'd0) begin
      w = CNT_W'(1);
    end else if (lw_ext > 32'(MAX_WIDTH)) begin
      w = CNT_W'(MAX_WIDTH);
    end else begin
      w = CNT_W'(lw_ext);
    end
    h = (cfg.frame_height == 13'd0) ? 13'd1 : cfg.frame_height;

    // a column left beyond a narrowed row is pinned to the last column
    col      = ({1'b0, column_count} >= w) ? COL_W'(w - CNT_W'(1)) : column_count;
    col_plus = {1'b0, col} + CNT_W'(1);
    is_last  = col_plus >= w;

    pix_live   = (in_opcode == OP_PIXEL) && (row_count < h);
    drain_live = (in_opcode == OP_DRAIN) && (row_count >= h);
    emit       = (pix_live && (row_count != 13'd0)) || drain_live;

    // second port: right neighbour, or left neighbour on the last column (own column if one wide)
    if (!is_last) begin
      raddr_b = col_plus[COL_W-1:0];
    end else if (col == '0) begin
      raddr_b = col;
    end else begin
      raddr_b = col - COL_W'(1);
    end
  end

  assign used     = q_count + QCNT_W'(stage_valid);
  assign in_ready = !rst && (used < QCNT_W'(QUEUE_DEPTH));
  assign accept   = in_valid && in_ready;

  assign we[0] = accept && pix_live && (bank_select == 1'b0);
  assign we[1] = accept && pix_live && (bank_select == 1'b1);

  for (genvar i = 0; i < 2; i++) begin : g_bank
    nrcf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk     (clk),
      .we      (we[i]),
      .waddr   (col),
      .wdata   (in_pixel),
      .raddr_a (col),
      .rdata_a (rd_a[i]),
      .raddr_b (raddr_b),
      .rdata_b (rd_b[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      bank_select  <= 1'b0;
      stage_valid  <= 1'b0;
    end else begin
      stage_valid <= accept && emit;
      if (accept && pix_live) begin
        if (is_last) begin
          column_count <= '0;
          bank_select  <= ~bank_select;
          row_count    <= row_count + 13'd1;
        end else begin
          column_count <= col_plus[COL_W-1:0];
        end
      end else if (accept && drain_live) begin
        if (is_last) begin
          column_count <= '0;
          row_count    <= '0;
          bank_select  <= 1'b0;
        end else begin
          column_count <= col_plus[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.px           <= in_pixel;
      stage.bank         <= bank_select;
      stage.is_drain     <= drain_live;
      stage.first_col    <= (col == '0);
      stage.last_col     <= is_last;
      stage.has_up       <= (row_count > 13'd1);
      stage.end_of_frame <= drain_live && is_last;
    end
  end

  // previous row lives in the bank not being written
  always_comb begin
    push                    = stage_valid;
    push_entry.px           = stage.px;
    push_entry.centre       = stage.bank ? rd_a[0] : rd_a[1];
    push_entry.side         = stage.bank ? rd_b[0] : rd_b[1];
    push_entry.above        = stage.bank ? rd_a[1] : rd_a[0];
    push_entry.is_drain     = stage.is_drain;
    push_entry.first_col    = stage.first_col;
    push_entry.last_col     = stage.last_col;
    push_entry.has_up       = stage.has_up;
    push_entry.end_of_frame = stage.end_of_frame;
  end

endmodule

`default_nettype wire

// ----- hdl/nrcf_queue.sv -----
// Short FIFO between front and back end; the front reserves space before accepting.
// Uses nrcf_pkg.
`default_nettype none

module nrcf_queue
  import nrcf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire entry_t      din,
  input  wire logic        pop,
  output entry_t           dout,
  output logic             not_empty,
  output logic [QCNT_W-1:0] count
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign dout      = mem[rd_ptr];
  assign not_empty = count != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/nrcf_back.sv -----
// Back end: forms the cross neighbourhood, clamps the centre sample and holds the
// result in the output register. Uses nrcf_pkg.
`default_nettype none

module nrcf_back
  import nrcf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] range_margin,
  input  wire entry_t     q_entry,
  input  wire logic       q_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_pixel,
  output logic            out_end_of_row,
  output logic            out_end_of_frame
);

  logic [7:0] last_centre;
  logic [7:0] up;
  logic [7:0] lf;
  logic [7:0] rt;
  logic [7:0] dn;
  logic [7:0] mn;
  logic [7:0] mx;
  logic signed [9:0] lo;
  logic signed [9:0] hi;
  logic signed [9:0] v;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    up = q_entry.has_up ? q_entry.above : q_entry.centre;
    if (q_entry.first_col) begin
      lf = q_entry.centre;
    end else if (q_entry.last_col) begin
      lf = q_entry.side;
    end else begin
      lf = last_centre;
    end
    rt = q_entry.last_col ? q_entry.centre : q_entry.side;
    dn = q_entry.is_drain ? q_entry.centre : q_entry.px;

    mn = up;
    mx = up;
    if (lf < mn) mn = lf;
    if (rt < mn) mn = rt;
    if (dn < mn) mn = dn;
    if (lf > mx) mx = lf;
    if (rt > mx) mx = rt;
    if (dn > mx) mx = dn;

    lo = $signed({2'b00, mn}) - $signed({2'b00, range_margin});
    hi = $signed({2'b00, mx}) + $signed({2'b00, range_margin});
    v  = $signed({2'b00, q_entry.centre});
    if (v < lo) v = lo;
    if (v > hi) v = hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      last_centre      <= q_entry.centre;
      out_pixel        <= v[7:0];
      out_end_of_row   <= q_entry.last_col;
      out_end_of_frame <= q_entry.end_of_frame;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/neighbor_range_clamp_filter.sv -----
// Neighbour range clamp filter top level: configuration registers, front end,
// queue and back end. Uses nrcf_pkg, nrcf_front, nrcf_queue, nrcf_back.
// Throughput: one input transaction per cycle while the queue has space; results lag the input by one row.
// Path: a transaction is registered in the front stage, queued, then clamped into the output register.
// Reset: line_width 640, frame_height 480, range_margin 30, counters cleared;
// line store contents undefined, no clearing pass.
`default_nettype none

module neighbor_range_clamp_filter
  import nrcf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,  // [7:0] pixel_in
  input  wire logic                 s_axis_tuser,  // [0] opcode
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [7:0]           m_axis_tdata,  // [7:0] pixel_out
  output logic                      m_axis_tlast,
  output logic                      m_axis_tuser,  // [0] end_of_frame
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t              cfg;
  logic              push;
  entry_t            push_entry;
  logic              pop;
  entry_t            q_entry;
  logic              q_valid;
  logic [QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width   <= 13'd640;
      cfg.frame_height <= 13'd480;
      cfg.range_margin <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   cfg.line_width   <= cfg_data;
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        REG_MAX_DIFF:     cfg.range_margin <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  nrcf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_opcode  (s_axis_tuser),
    .in_pixel   (s_axis_tdata),
    .q_count    (q_count),
    .push       (push),
    .push_entry (push_entry)
  );

  nrcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_entry),
    .pop       (pop),
    .dout      (q_entry),
    .not_empty (q_valid),
    .count     (q_count)
  );

  nrcf_back u_back (
    .clk              (clk),
    .rst              (rst),
    .range_margin     (cfg.range_margin),
    .q_entry          (q_entry),
    .q_valid          (q_valid),
    .pop              (pop),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_pixel        (m_axis_tdata),
    .out_end_of_row   (m_axis_tlast),
    .out_end_of_frame (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- bench/tb_neighbor_range_clamp_filter.sv -----
// Testbench for neighbor_range_clamp_filter: streams random and directed planes,
// predicts every clamped pixel in a scoreboard class and checks each result.
// Depends on nrcf_pkg and the neighbor_range_clamp_filter RTL only.
`timescale 1ns / 1ps

module tb_neighbor_range_clamp_filter;
  import nrcf_pkg::*;

  localparam int RANDOM_ITEMS  = 1000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] px;
    logic       eor;
    logic       eof;
  } pix_result_t;

  class clamp_scoreboard;
    bit [7:0]    line_mem [2*MAX_WIDTH];
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned diff_reg;
    int unsigned col_count;
    int unsigned row_count;
    bit          bank;
    pix_result_t pending_q[$];
    int          errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      diff_reg   = 30;
      col_count  = 0;
      row_count  = 0;
      bank       = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_LINE_WIDTH:   width_reg  = 32'(v);
        REG_FRAME_HEIGHT: height_reg = 32'(v);
        REG_MAX_DIFF:     diff_reg   = 32'(v[7:0]);
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function int pending_count();
      return pending_q.size();
    endfunction

    // Result for column c of the row in the previous-row bank
    function pix_result_t neighbour_clamp(int unsigned c, int unsigned w, logic [7:0] below,
                                          bit has_below, bit last_of_frame);
      pix_result_t r;
      int unsigned prev_base;
      int unsigned cur_base;
      int centre, up, lf, rt, dn, mn, mx, v;
      prev_base = (bank ? 0 : 1) * MAX_WIDTH;
      cur_base  = (bank ? 1 : 0) * MAX_WIDTH;
      centre = int'(line_mem[prev_base + c]);
      up = (row_count >= 2) ? int'(line_mem[cur_base + c]) : centre;
      lf = (c > 0) ? int'(line_mem[prev_base + c - 1]) : centre;
      rt = (c + 1 < w) ? int'(line_mem[prev_base + c + 1]) : centre;
      dn = has_below ? int'(below) : centre;
      mn = up;
      mx = up;
      if (lf < mn) mn = lf;
      if (rt < mn) mn = rt;
      if (dn < mn) mn = dn;
      if (lf > mx) mx = lf;
      if (rt > mx) mx = rt;
      if (dn > mx) mx = dn;
      v = centre;
      if (v < mn - int'(diff_reg)) v = mn - int'(diff_reg);
      if (v > mx + int'(diff_reg)) v = mx + int'(diff_reg);
      r.px  = v[7:0];
      r.eor = (c + 1 >= w);
      r.eof = last_of_frame;
      return r;
    endfunction

    function void note_input(logic op, logic [7:0] px);
      int unsigned w, h, c;
      w = eff_width();
      h = eff_height();
      c = col_count;
      if (c >= w) c = w - 1;
      if (op == OP_PIXEL) begin
        if (row_count >= h) return;
        if (row_count >= 1) pending_q.push_back(neighbour_clamp(c, w, px, 1'b1, 1'b0));
        line_mem[(bank ? MAX_WIDTH : 0) + c] = px;
        if (c + 1 >= w) begin
          col_count = 0;
          bank      = ~bank;
          row_count++;
        end else begin
          col_count = c + 1;
        end
      end else begin
        if (row_count < h) return;
        pending_q.push_back(neighbour_clamp(c, w, 8'd0, 1'b0, c + 1 >= w));
        if (c + 1 >= w) begin
          col_count = 0;
          row_count = 0;
          bank      = 1'b0;
        end else begin
          col_count = c + 1;
        end
      end
    endfunction

    task report(string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] px, logic eor, logic eof);
      pix_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result pixel_out=%0d", px));
        return;
      end
      want = pending_q.pop_front();
      if (px !== want.px)
        report($sformatf("pixel_out %0d, predicted %0d", px, want.px));
      if (eor !== want.eor)
        report($sformatf("end_of_row %b, predicted %b", eor, want.eor));
      if (eof !== want.eof)
        report($sformatf("end_of_frame %b, predicted %b", eof, want.eof));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] pixel_in
  logic                 s_axis_tuser;   // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [7:0]           m_axis_tdata;   // [7:0] pixel_out
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;   // [0] end_of_frame
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  clamp_scoreboard sb;
  int              cycle_count;
  int              texture;
  int              random_items;
  logic            calm;

  neighbor_range_clamp_filter dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // periodic stretch with no idling on either side
  assign calm = (cycle_count % 4000) >= 2600;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 3) begin
        stall_left    = $urandom_range(0, 3);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] gen_pixel();
    int t;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2, 3, 4: return 8'($urandom_range(0, 255));
      default: begin
        t = texture + int'($urandom_range(0, 24)) - 12;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        texture = t;
        return 8'(t);
      end
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [7:0] px);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 3) begin
      gap           = $urandom_range(1, 4);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = px;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input(op, px);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // block may still be busy on a transaction that gave no result
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int d);
    settle();
    write_reg(REG_LINE_WIDTH, CFG_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
    write_reg(REG_MAX_DIFF, CFG_W'(d));
  endtask

  task automatic run_frame(input int w, input int h, input int d, input bit squeeze);
    int w_eff, h_eff;
    w_eff = (w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
    h_eff = (h == 0) ? 1 : h;
    configure(w, h, d);
    for (int r = 0; r < h_eff; r++) begin
      for (int c = 0; c < w_eff; c++) begin
        // early drain: ignored
        if ($urandom_range(0, 99) < 4) send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        send_item(OP_PIXEL, gen_pixel());
        random_items++;
        if (squeeze && r == h_eff / 2 && c == w_eff / 2) wait_drained();
      end
    end
    for (int c = 0; c < w_eff; c++) begin
      // pixel while draining: ignored
      if ($urandom_range(0, 99) < 4) send_item(OP_PIXEL, gen_pixel());
      send_item(OP_DRAIN, 8'($urandom_range(0, 255)));
      random_items++;
    end
  endtask

  initial begin
    logic [7:0] dir_px [9];
    int w, h, d;
    dir_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd127, 8'd200};
    sb            = new();
    texture       = 128;
    random_items  = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = OP_PIXEL;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LINE_WIDTH;
    cfg_data      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 3x3 plane, checkerboard in its first two rows, no widening, with ignored transactions either side
    configure(3, 3, 0);
    send_item(OP_DRAIN, 8'hFF);
    for (int i = 0; i < 9; i++) send_item(OP_PIXEL, dir_px[i]);
    send_item(OP_PIXEL, 8'h5A);
    for (int i = 0; i < 3; i++) send_item(OP_DRAIN, 8'h00);

    // zero width and height act as one
    configure(0, 0, 255);
    send_item(OP_PIXEL, 8'hA5);
    send_item(OP_DRAIN, 8'h5A);

    random_items = 0;
    run_frame(12, 5, 20, 1'b1);
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = 1;
        1, 2, 3, 4, 5: w = $urandom_range(2, 8);
        6, 7, 8: w = $urandom_range(9, 32);
        default: w = $urandom_range(33, 96);
      endcase
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0: d = 0;
        1: d = 255;
        2, 3, 4, 5, 6: d = $urandom_range(0, 24);
        default: d = $urandom_range(0, 255);
      endcase
      run_frame(w, h, d, 1'b0);
    end

    // tall single-column plane
    run_frame(1, 300, 7, 1'b1);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
